### rtl/rbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_pkg
// shared types and constants of the rgb 3x3 box blur
// ----------------------------------------------------------------------------
package rbb_pkg;

    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int SUM_W  = 12;          // nine 8-bit samples
    localparam int POS_W  = 10;          // width of reported positions
    localparam int DIM_W  = 11;          // width of the size registers
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // channel offsets inside a packed pixel {red, green, blue}
    localparam int RED_LO   = 2 * CH_W;
    localparam int GREEN_LO = CH_W;
    localparam int BLUE_LO  = 0;

    // s / 9 == (s * 7282) >> 16 for every s up to 9 * 255
    localparam int RECIP_W = 13;
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
    localparam int RECIP_SHIFT = 16;

    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - 2 * POS_W - PIX_W;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

    typedef enum logic
    {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             emit_int;
        logic             emit_bord;
    } rbb_entry_t;

endpackage

### rtl/rbb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_front
// pixel intake: position counters, line memory, window columns, channel sums
// ----------------------------------------------------------------------------
module rbb_front
    import rbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic [$clog2(MAX_WIDTH):0]    width,
    input  logic [$clog2(MAX_HEIGHT):0]   height,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [PIX_W-1:0]              in_pixel,
    input  logic [QAW:0]                  q_count,
    output logic                          q_push,
    output rbb_entry_t                    q_entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic               a_valid_reg;
    logic [PIX_W-1:0]   a_pix_reg;
    logic [CW-1:0]      a_col_reg;
    logic [RW-1:0]      a_row_reg;
    logic               a_int_reg;
    logic               a_bord_reg;
    logic [2*PIX_W-1:0] rd_reg;
    logic [PIX_W-1:0]   win_reg [6];

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

    logic               in_acc;
    logic [CW:0]        col_p1;
    logic [RW:0]        row_p1;
    logic               at_int;
    logic               at_bord;
    logic [PIX_W-1:0]   up;
    logic [PIX_W-1:0]   mid;
    logic [SUM_W-1:0]   sums [3];
    logic [CW+POS_W-1:0] col_ext;
    logic [RW+POS_W-1:0] row_ext;

    // room for this beat and the one still in the sum stage
    assign in_ready = ({1'b0, q_count} + {{QAW+1{1'b0}}, a_valid_reg}) < (QAW+2)'(QDEPTH);
    assign in_acc   = in_valid && in_ready;

    assign col_p1  = {1'b0, col_reg} + {{CW{1'b0}}, 1'b1};
    assign row_p1  = {1'b0, row_reg} + {{RW{1'b0}}, 1'b1};
    assign at_int  = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
    assign at_bord = (row_reg == '0) || (col_reg == '0) || (row_p1 == height)
                     || (col_p1 == width);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (col_p1 == width)
            begin
                col_next = '0;
                row_next = (row_p1 == height) ? '0 : row_p1[RW-1:0];
            end
            else
            begin
                col_next = col_p1[CW-1:0];
            end
        end
    end

    assign up  = rd_reg[2*PIX_W-1:PIX_W];
    assign mid = rd_reg[PIX_W-1:0];

    // per channel sum of the 3x3 window
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sums[ch] = SUM_W'(up[RED_LO-ch*CH_W +: CH_W])
                     + SUM_W'(mid[RED_LO-ch*CH_W +: CH_W])
                     + SUM_W'(a_pix_reg[RED_LO-ch*CH_W +: CH_W]);
            for (int i = 0; i < 6; i++)
            begin
                sums[ch] = sums[ch] + SUM_W'(win_reg[i][RED_LO-ch*CH_W +: CH_W]);
            end
        end
    end

    assign col_ext = {{POS_W{1'b0}}, a_col_reg};
    assign row_ext = {{POS_W{1'b0}}, a_row_reg};

    always_comb
    begin
        q_entry.sum_r     = sums[0];
        q_entry.sum_g     = sums[1];
        q_entry.sum_b     = sums[2];
        q_entry.pixel     = a_pix_reg;
        q_entry.row       = row_ext[POS_W-1:0];
        q_entry.col       = col_ext[POS_W-1:0];
        q_entry.emit_int  = a_int_reg;
        q_entry.emit_bord = a_bord_reg;
    end

    assign q_push = a_valid_reg && (a_int_reg || a_bord_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= in_acc;
            if (restart)
            begin
                for (int i = 0; i < 6; i++)
                begin
                    win_reg[i] <= '0;
                end
            end
            else if (a_valid_reg)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= up;
                win_reg[4] <= mid;
                win_reg[5] <= a_pix_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_pix_reg  <= in_pixel;
            a_col_reg  <= col_reg;
            a_row_reg  <= row_reg;
            a_int_reg  <= at_int;
            a_bord_reg <= at_bord;
        end
    end

    // line memory entry: {two rows above, one row above}
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd_reg <= line_mem[col_reg];
        end
        if (a_valid_reg)
        begin
            line_mem[a_col_reg] <= {mid, a_pix_reg};
        end
    end

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < width)
        else $error("column counter beyond row width");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (q_count < (QAW+1)'(QDEPTH)))
        else $error("sum stage holds a beat with the queue full");

    a_int_window: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && at_int) |=> (a_int_reg && a_col_reg >= CW'(2) && a_row_reg >= RW'(2)))
        else $error("interior flag without a full window");
`endif

endmodule

### rtl/rbb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_queue
// short register fifo between the sum stage and the output sequencer
// ----------------------------------------------------------------------------
module rbb_queue
    import rbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rbb_entry_t  push_entry,
    input  logic        pop,
    output rbb_entry_t  head,
    output logic [QAW:0] count
);

    rbb_entry_t     slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/rbb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_back
// divide by nine and emit one or two result beats per queue entry
// ----------------------------------------------------------------------------
module rbb_back
    import rbb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  rbb_entry_t            head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    logic               out_valid_reg, out_valid_next;
    logic               phase_reg, phase_next;
    logic [POS_W-1:0]   row_reg;
    logic [POS_W-1:0]   col_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               last_reg;

    logic               load;
    logic               sel_int;
    logic [SUM_W+RECIP_W-1:0] prod_r, prod_g, prod_b;
    logic [PIX_W-1:0]   blur;
    logic [POS_W-1:0]   res_row, res_col;
    logic [PIX_W-1:0]   res_pix;
    logic               res_last;

    assign prod_r = (SUM_W+RECIP_W)'(head.sum_r) * (SUM_W+RECIP_W)'(RECIP_9);
    assign prod_g = (SUM_W+RECIP_W)'(head.sum_g) * (SUM_W+RECIP_W)'(RECIP_9);
    assign prod_b = (SUM_W+RECIP_W)'(head.sum_b) * (SUM_W+RECIP_W)'(RECIP_9);
    assign blur   = {prod_r[RECIP_SHIFT +: CH_W], prod_g[RECIP_SHIFT +: CH_W],
                     prod_b[RECIP_SHIFT +: CH_W]};

    assign load    = q_valid && (!out_valid_reg || out_ready);
    assign sel_int = head.emit_int && !phase_reg;

    always_comb
    begin
        if (sel_int)
        begin
            res_row  = head.row - 1'b1;
            res_col  = head.col - 1'b1;
            res_pix  = blur;
            res_last = !head.emit_bord;
        end
        else
        begin
            res_row  = head.row;
            res_col  = head.col;
            res_pix  = head.pixel;
            res_last = 1'b1;
        end
    end

    assign pop = load && res_last;

    always_comb
    begin
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            phase_next     = !res_last;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg  <= res_row;
            col_reg  <= res_col;
            pix_reg  <= res_pix;
            last_reg <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = last_reg;
    assign out_data  = {{OUT_PAD_W{1'b0}},
                        pix_reg[BLUE_LO +: CH_W], pix_reg[GREEN_LO +: CH_W],
                        pix_reg[RED_LO +: CH_W], col_reg, row_reg};

`ifndef SYNTHESIS
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (q_valid && head.emit_int && head.emit_bord))
        else $error("second beat pending without a two-result entry");
`endif

endmodule

### rtl/rgb_box_blur_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// 3x3 box blur over a raster stream of rgb pixels
// ----------------------------------------------------------------------------
// The front end counts row and column, reads the line memory (one 48-bit
// entry per column holding the two rows above, one read and one write port)
// and sums the 3x3 window of each channel; the sums go through a four-entry
// queue to the back end, which divides by nine and drives a registered
// output beat. Border pixels come out as copies, an interior pixel comes out
// when its lower-right neighbour arrives, so a pixel causes zero, one or two
// result beats (interior first, then the border copy). Sustained rate is one
// pixel per clock while each pixel yields at most one beat and the output is
// not stalled; a pixel with two beats keeps its queue entry until the second
// beat is loaded. An input beat passes the sum stage, the queue and the
// output register. Any register write restarts the frame at row 0, column
// 0; write only while the block is idle. Sizes of 0 act as 1, sizes above
// the maximum act as the maximum. No clearing pass runs after reset.
module rgb_box_blur_3x3
    import rbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    // apb configuration: 0x0 image_width, 0x4 image_height
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // pixel in: [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,

    // result out: [9:0] out_row, [19:10] out_col, [27:20] red_out,
    // [35:28] green_out, [43:36] blue_out, [47:44] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast      // last_of_run
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int W_RST = (MAX_WIDTH  < 1024) ? MAX_WIDTH  : 1024;
    localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    // raw register values: the low 11 bits of a write, read back unclamped
    logic [DIM_W-1:0] width_raw_reg, width_raw_next;
    logic [DIM_W-1:0] height_raw_reg, height_raw_next;
    // clamped sizes used by the datapath
    logic [CW:0]      width_eff_reg, width_eff_next;
    logic [RW:0]      height_eff_reg, height_eff_next;

    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    logic [31:0]      clamp_w, clamp_h;

    logic             q_push;
    logic             q_pop;
    rbb_entry_t       q_in;
    rbb_entry_t       q_head;
    logic [QAW:0]     q_count;

    function automatic logic [31:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
        logic [31:0] v32;
        v32 = {{(32-DIM_W){1'b0}}, v};
        if (v32 == 32'd0)
        begin
            return 32'd1;
        end
        else if (v32 > 32'(maxv))
        begin
            return 32'(maxv);
        end
        return v32;
    endfunction

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign clamp_w = clamp_dim(pwdata[DIM_W-1:0], MAX_WIDTH);
    assign clamp_h = clamp_dim(pwdata[DIM_W-1:0], MAX_HEIGHT);

    always_comb
    begin
        width_raw_next  = width_raw_reg;
        height_raw_next = height_raw_reg;
        width_eff_next  = width_eff_reg;
        height_eff_next = height_eff_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_WIDTH:
                begin
                    width_raw_next = pwdata[DIM_W-1:0];
                    width_eff_next = clamp_w[CW:0];
                end
                REG_HEIGHT:
                begin
                    height_raw_next = pwdata[DIM_W-1:0];
                    height_eff_next = clamp_h[RW:0];
                end
                default:
                begin
                    width_raw_next = width_raw_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_raw_reg  <= DIM_RESET;
            height_raw_reg <= DIM_RESET;
            width_eff_reg  <= (CW+1)'(W_RST);
            height_eff_reg <= (RW+1)'(H_RST);
        end
        else
        begin
            width_raw_reg  <= width_raw_next;
            height_raw_reg <= height_raw_next;
            width_eff_reg  <= width_eff_next;
            height_eff_reg <= height_eff_next;
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_raw_reg};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_raw_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // front end: counters, line memory, window sums
    // ------------------------------------------------------------------
    rbb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_wr),       // any write restarts the frame
        .width    (width_eff_reg),
        .height   (height_eff_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_pixel ({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    // ------------------------------------------------------------------
    // queue between the two halves
    // ------------------------------------------------------------------
    rbb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .count      (q_count)
    );

    // ------------------------------------------------------------------
    // back end: divide by nine, sequence result beats
    // ------------------------------------------------------------------
    rbb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_count != '0),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

### tb/blur_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur_checker
// watches the pixel, result and register channels of the box blur, predicts
// every result beat from the accepted pixels and compares it field by field
// ----------------------------------------------------------------------------
module blur_checker
    import rbb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,

    // [7:0] red_in, [15:8] green_in, [23:16] blue_in
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,

    // [9:0] out_row, [19:10] out_col, [27:20] red_out, [35:28] green_out,
    // [43:36] blue_out, [47:44] zero
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tlast,

    output int          fail_count,
    output int          pending_beats
);

    typedef struct packed
    {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed
    {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        rgb_t             px;
        logic             tail;
    } blur_beat_t;

    // own copy of the line memories, window and frame position
    rgb_t        upper_line_mem  [MAX_WIDTH];
    rgb_t        middle_line_mem [MAX_WIDTH];
    rgb_t        window_cols     [6];
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned row_pos;
    int unsigned col_pos;
    blur_beat_t  blurred_q [$];
    int          errs;

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    task automatic restart_frame();
        row_pos = 0;
        col_pos = 0;
        foreach (window_cols[i])
            window_cols[i] = '0;
    endtask

    // one accepted pixel: queue the interior result first, then the border copy
    task automatic blur_step(input rgb_t px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned sr;
        int unsigned sg;
        int unsigned sb;
        int          n;
        rgb_t        up;
        rgb_t        mid;
        blur_beat_t  found [2];
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, MAX_HEIGHT);
        if (row_pos >= h || col_pos >= w)
            restart_frame();
        r   = row_pos;
        c   = col_pos;
        n   = 0;
        up  = upper_line_mem[c];
        mid = middle_line_mem[c];
        if (r >= 2 && c >= 2 && r + 1 <= h && c + 1 <= w)
        begin
            sr = up.red   + mid.red   + px.red;
            sg = up.green + mid.green + px.green;
            sb = up.blue  + mid.blue  + px.blue;
            for (int i = 0; i < 6; i++)
            begin
                sr += window_cols[i].red;
                sg += window_cols[i].green;
                sb += window_cols[i].blue;
            end
            found[n].row      = POS_W'(r - 1);
            found[n].col      = POS_W'(c - 1);
            found[n].px.red   = CH_W'(sr / 9);
            found[n].px.green = CH_W'(sg / 9);
            found[n].px.blue  = CH_W'(sb / 9);
            found[n].tail     = 1'b0;
            n++;
        end
        if (r == 0 || c == 0 || r + 1 == h || c + 1 == w)
        begin
            found[n].row  = POS_W'(r);
            found[n].col  = POS_W'(c);
            found[n].px   = px;
            found[n].tail = 1'b0;
            n++;
        end
        if (n > 0)
            found[n-1].tail = 1'b1;
        for (int i = 0; i < n; i++)
            blurred_q.push_back(found[i]);

        window_cols[0] = window_cols[3];
        window_cols[1] = window_cols[4];
        window_cols[2] = window_cols[5];
        window_cols[3] = up;
        window_cols[4] = mid;
        window_cols[5] = px;
        upper_line_mem[c]  = mid;
        middle_line_mem[c] = px;

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errs++;
        end
    endtask

    task automatic check_beat();
        blur_beat_t want;
        if (blurred_q.size() == 0)
        begin
            $display("%0t: result beat expected none got %h", $time, m_axis_tdata);
            errs++;
        end
        else
        begin
            want = blurred_q.pop_front();
            check_field("out_row",     16'(want.row),      16'(m_axis_tdata[9:0]));
            check_field("out_col",     16'(want.col),      16'(m_axis_tdata[19:10]));
            check_field("red_out",     16'(want.px.red),   16'(m_axis_tdata[27:20]));
            check_field("green_out",   16'(want.px.green), 16'(m_axis_tdata[35:28]));
            check_field("blue_out",    16'(want.px.blue),  16'(m_axis_tdata[43:36]));
            check_field("pad",         16'd0,              16'(m_axis_tdata[47:44]));
            check_field("last_of_run", 16'(want.tail),     16'(m_axis_tlast));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            restart_frame();
            blurred_q.delete();
            errs = 0;
            fail_count    <= 0;
            pending_beats <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[2]))
                    REG_WIDTH:  width_reg  = pwdata[DIM_W-1:0];
                    REG_HEIGHT: height_reg = pwdata[DIM_W-1:0];
                    default:    width_reg  = width_reg;
                endcase
                restart_frame();
            end
            if (s_axis_tvalid && s_axis_tready)
                blur_step('{red:   s_axis_tdata[7:0],
                            green: s_axis_tdata[15:8],
                            blue:  s_axis_tdata[23:16]});
            if (m_axis_tvalid && m_axis_tready)
                check_beat();
            fail_count    <= errs;
            pending_beats <= blurred_q.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// pixel stream stimulus and verdict for the rgb 3x3 box blur; a checker
// beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module testbench;
    import rbb_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 600;
    localparam int CYCLE_LIMIT   = 400000;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    // register port, write only from this side
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // pixel in: [7:0] red_in, [15:8] green_in, [23:16] blue_in
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;

    // result out: [9:0] out_row, [19:10] out_col, [27:20] red_out,
    // [35:28] green_out, [43:36] blue_out, [47:44] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    int          fail_count;
    int          pending_beats;
    int          cycle_count = 0;
    int          stall_left  = 0;
    logic        steady_source = 1'b0;     // phase with no source gaps
    logic        steady_sink   = 1'b0;     // phase with no sink stalls

    always #HALF_PERIOD clk = ~clk;

    rgb_box_blur_3x3 i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    blur_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sample biased toward the channel extremes
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result sink: random back-pressure, switched off in steady phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!steady_sink)
                stall_left <= pick_gap();
        end
    end

    // setup cycle then access cycle; the register takes the write at the
    // edge that ends the access cycle, and the task returns once the port is idle
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // one pixel beat, held until the block takes it; valid stays up when
    // the next beat follows without a gap
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        int gap;
        gap = steady_source ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blue, green, red};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // stop sending and wait for every predicted beat, then let the pipe empty
    // of pixels that cause no result
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        settle();
        write_reg(REG_WIDTH, 32'(w));
        write_reg(REG_HEIGHT, 32'(h));
    endtask

    // random pixels on one frame size; pause_at >= 0 holds the source off
    // until all results are out, in the middle of the stream
    task automatic run_phase(input int w, input int h, input int count, input int pause_at);
        set_frame(w, h);
        steady_source = ($urandom_range(0, 3) == 0);
        steady_sink   = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                settle();
            send_pixel(pick_sample(), pick_sample(), pick_sample());
        end
    endtask

    initial
    begin
        int sent;
        int phase_idx;
        int w;
        int h;
        int count;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest frame with an interior pixel, all samples at full scale:
        // nine samples of 255 must still divide back to 255; the centre
        // pixel arrives with no result and the last pixel yields two beats
        set_frame(3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel(8'hFF, 8'hFF, 8'hFF);

        // second frame right after the counters wrap, mixed extremes
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF, 8'(i * 28));

        // zero width acts as one column, oversize height as the maximum
        set_frame(0, 2047);
        for (int i = 0; i < 3; i++)
            send_pixel(8'h01, 8'h80, 8'hFE);

        // oversize width acts as the maximum, zero height as one row
        set_frame(2047, 0);
        for (int i = 0; i < 3; i++)
            send_pixel(8'hFE, 8'h7F, 8'h01);

        // random phases, mostly small frames with whole frames passing
        // through, some with degenerate or maximum sizes
        sent      = 0;
        phase_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    w     = $urandom_range(0, 1) ? 1024 : 2047;
                    h     = $urandom_range(1, 6);
                    count = $urandom_range(8, 40);
                end
                1:
                begin
                    w     = $urandom_range(3, 10);
                    h     = $urandom_range(0, 1) ? $urandom_range(0, 2)
                                                 : ($urandom_range(0, 1) ? 1024 : 2047);
                    count = w * 3 + $urandom_range(0, w);
                end
                2:
                begin
                    w     = $urandom_range(0, 2);
                    h     = $urandom_range(1, 12);
                    count = $urandom_range(5, 30);
                end
                default:
                begin
                    w     = $urandom_range(3, 12);
                    h     = $urandom_range(3, 8);
                    count = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
                end
            endcase
            run_phase(w, h, count, (phase_idx == 0) ? count / 2 : -1);
            sent += count;
            phase_idx++;
        end

        settle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/rbb_pkg.sv
rtl/rbb_front.sv
rtl/rbb_queue.sv
rtl/rbb_back.sv
rtl/rgb_box_blur_3x3.sv
tb/blur_checker.sv
tb/testbench.sv
